// ===== design/bhit_pkg.sv =====
// ----------------------------------------------------------------------------
// bhit_pkg
// Shared types and codes for the bucketed hash index table.
// ----------------------------------------------------------------------------
package bhit_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_BUCKET_FULL = 2'd2,
    ST_TABLE_FULL  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_HASH_MULT   = 1'b0,
    CFG_BUCKET_BITS = 1'b1
  } cfg_reg_t;

  localparam int MULT_WIDTH  = 31;
  localparam int BBITS_WIDTH = 4;
  localparam int IN_KEY_W    = 31;
  localparam int SLOT_WIDTH  = 8;
  localparam int NSLOT_WIDTH = 9;
  localparam int HASH_WIDTH  = 32;

  typedef struct packed {
    action_t               action;
    logic [IN_KEY_W-1:0]   key;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_WIDTH-1:0] slot_index;
    status_t               status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mult;
    logic fold;
    logic read;
    logic eval;
    logic clr_step;
    logic resp_trivial;
    logic resp_clear;
  } cmd_t;

  typedef struct packed {
    logic op_hash;
    logic op_clear;
    logic clr_last;
  } stat_t;

endpackage

// ===== design/bhit_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhit_ctrl
// Sequencer: hash, bucket read, evaluate/write back, and the clearing sweep.
// ----------------------------------------------------------------------------
module bhit_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  bhit_pkg::stat_t stat,
  output bhit_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MULT  = 6'b000010,
    S_FOLD  = 6'b000100,
    S_READ  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   reply_r, reply_nxt;

  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.op_clear) begin
            state_nxt = S_CLEAR;
            reply_nxt = 1'b1;
          end else if (stat.op_hash) begin
            state_nxt = S_MULT;
          end else begin
            cmd.resp_trivial = 1'b1;
          end
        end
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.resp_clear = reply_r;
          reply_nxt      = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_clear_reply_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_clear |-> (stat.clr_last && state_r == S_CLEAR))
    else $error("clear reply before end of sweep");

  a_hash_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && stat.op_hash) |-> ##4 cmd.eval)
    else $error("lookup/insert did not reach evaluate in four cycles");

endmodule

// ===== design/bhit_datapath.sv =====
// ----------------------------------------------------------------------------
// bhit_datapath
// Config registers, multiply/fold hash, bucket memory and result register.
// ----------------------------------------------------------------------------
module bhit_datapath #(
  parameter int WAYS            = 4,
  parameter int MAX_BUCKET_BITS = 10,
  parameter int KEY_WIDTH       = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bhit_pkg::in_item_t  in_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bhit_pkg::cfg_reg_t  cfg_index,
  input  logic [bhit_pkg::MULT_WIDTH-1:0] cfg_data,
  input  bhit_pkg::cmd_t      cmd,
  output bhit_pkg::stat_t     stat,
  output logic                out_strobe,
  output bhit_pkg::out_item_t out_item
);

  localparam int ROWS = 1 << MAX_BUCKET_BITS;
  localparam int BBW  = $clog2(MAX_BUCKET_BITS + 1);
  localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SW   = bhit_pkg::SLOT_WIDTH;

  typedef logic [WAYS-1:0][KEY_WIDTH-1:0] row_keys_t;
  typedef logic [WAYS-1:0][SW-1:0]        row_idx_t;

  logic [bhit_pkg::MULT_WIDTH-1:0]  mult_r;
  logic [bhit_pkg::BBITS_WIDTH-1:0] bbits_r;
  bhit_pkg::in_item_t               in_r;
  logic [bhit_pkg::HASH_WIDTH-1:0]  prod_r;
  logic [MAX_BUCKET_BITS-1:0]       bucket_r;
  logic [MAX_BUCKET_BITS-1:0]       clr_cnt_r;
  logic [bhit_pkg::NSLOT_WIDTH-1:0] next_slot_r;
  row_keys_t                        rd_keys_r;
  row_idx_t                         rd_idx_r;
  logic                             out_strobe_r;
  bhit_pkg::out_item_t              out_r;

  row_keys_t key_mem [ROWS];
  row_idx_t  idx_mem [ROWS];

  logic [KEY_WIDTH-1:0]            key_w;
  logic [BBW-1:0]                  b_eff;
  logic [bhit_pkg::HASH_WIDTH-1:0] hval;
  logic [MAX_BUCKET_BITS-1:0]      folds [1:MAX_BUCKET_BITS];
  logic                            hit, emp, ins_ok;
  logic [WW-1:0]                   hit_w, emp_w;
  bhit_pkg::out_item_t             eval_res;
  row_keys_t                       wr_keys;
  row_idx_t                        wr_idx;
  logic                            mem_we;
  logic [MAX_BUCKET_BITS-1:0]      mem_wa;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r  <= bhit_pkg::MULT_WIDTH'(1);
      bbits_r <= bhit_pkg::BBITS_WIDTH'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bhit_pkg::CFG_HASH_MULT:   mult_r  <= cfg_data;
        bhit_pkg::CFG_BUCKET_BITS: bbits_r <= cfg_data[bhit_pkg::BBITS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign stat.op_hash  = ((in_item.action == bhit_pkg::ACT_LOOKUP) ||
                          (in_item.action == bhit_pkg::ACT_INSERT)) &&
                         (in_item.key[KEY_WIDTH-1:0] != '0);
  assign stat.op_clear = (in_item.action == bhit_pkg::ACT_CLEAR);
  assign stat.clr_last = &clr_cnt_r;

  assign key_w = in_r.key[KEY_WIDTH-1:0];

  always_comb begin
    if (bbits_r == '0) begin
      b_eff = BBW'(1);
    end else if ({1'b0, bbits_r} > (bhit_pkg::BBITS_WIDTH + 1)'(MAX_BUCKET_BITS)) begin
      b_eff = BBW'(MAX_BUCKET_BITS);
    end else begin
      b_eff = BBW'(bbits_r);
    end
  end

  // fixed xor folds, one per chunk width
  assign hval = prod_r | bhit_pkg::HASH_WIDTH'(1);
  always_comb begin
    int j;
    for (int b = 1; b <= MAX_BUCKET_BITS; b++) begin
      folds[b] = '0;
      j = 0;
      for (int k = 0; k < bhit_pkg::HASH_WIDTH; k++) begin
        folds[b][j] = folds[b][j] ^ hval[k];
        j = (j == b - 1) ? 0 : j + 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_item;
    if (cmd.mult) prod_r <= bhit_pkg::HASH_WIDTH'(key_w) * bhit_pkg::HASH_WIDTH'(mult_r);
    if (cmd.fold) bucket_r <= folds[b_eff];
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_keys_r <= key_mem[bucket_r];
      rd_idx_r  <= idx_mem[bucket_r];
    end
  end

  // highest matching / empty way wins
  always_comb begin
    hit   = 1'b0;
    emp   = 1'b0;
    hit_w = '0;
    emp_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_keys_r[w] == key_w) begin
        hit   = 1'b1;
        hit_w = WW'(w);
      end
      if (rd_keys_r[w] == '0) begin
        emp   = 1'b1;
        emp_w = WW'(w);
      end
    end
  end

  always_comb begin
    ins_ok   = 1'b0;
    eval_res = '{slot_index: '0, status: bhit_pkg::ST_NOT_FOUND};
    if (in_r.action == bhit_pkg::ACT_INSERT) begin
      if (next_slot_r[SW]) begin
        eval_res.status = bhit_pkg::ST_TABLE_FULL;
      end else if (emp) begin
        ins_ok              = 1'b1;
        eval_res.slot_index = next_slot_r[SW-1:0];
        eval_res.status     = bhit_pkg::ST_DONE;
      end else begin
        eval_res.status = bhit_pkg::ST_BUCKET_FULL;
      end
    end else if (hit) begin
      eval_res.slot_index = rd_idx_r[hit_w];
      eval_res.status     = bhit_pkg::ST_DONE;
    end
  end

  always_comb begin
    wr_keys = rd_keys_r;
    wr_idx  = rd_idx_r;
    wr_keys[emp_w] = key_w;
    wr_idx[emp_w]  = next_slot_r[SW-1:0];
    if (cmd.clr_step) begin
      wr_keys = '0;
      wr_idx  = '0;
    end
  end

  assign mem_we = cmd.clr_step || (cmd.eval && ins_ok);
  assign mem_wa = cmd.clr_step ? clr_cnt_r : bucket_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= wr_keys;
      idx_mem[mem_wa] <= wr_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      next_slot_r <= bhit_pkg::NSLOT_WIDTH'(1);
    end else begin
      if (cmd.load && stat.op_clear) begin
        clr_cnt_r   <= '0;
        next_slot_r <= bhit_pkg::NSLOT_WIDTH'(1);
      end else begin
        if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
        if (cmd.eval && ins_ok) next_slot_r <= next_slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.eval || cmd.resp_trivial || cmd.resp_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_r <= eval_res;
    end else if (cmd.resp_clear) begin
      out_r <= '{slot_index: '0, status: bhit_pkg::ST_DONE};
    end else if (cmd.resp_trivial) begin
      out_r <= '{slot_index: '0, status: bhit_pkg::ST_NOT_FOUND};
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  a_next_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_slot_r != '0) && (next_slot_r <= bhit_pkg::NSLOT_WIDTH'(256)))
    else $error("next slot out of range");

  a_fail_has_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.status != bhit_pkg::ST_DONE) |-> (out_r.slot_index == '0))
    else $error("failed beat carries an index");

endmodule

// ===== design/bucketed_hash_index_table_top.sv =====
// ----------------------------------------------------------------------------
// bucketed_hash_index_table_top
// Key to slot index map through a WAYS-way (four by default) bucketed hash table.
// ----------------------------------------------------------------------------
// Lookup/insert: multiply, fold, bucket read, evaluate/write back, then the
//   result register; busy stays high through evaluate, ignoring any start.
// Reserved key or unused action: result next cycle, one item per cycle.
// Clear: one bucket row per cycle over all 2**MAX_BUCKET_BITS rows, then the result.
// Reset runs the same sweep with busy high; results are never stalled.
module bucketed_hash_index_table_top #(
  parameter int WAYS            = 4,
  parameter int MAX_BUCKET_BITS = 10,
  parameter int KEY_WIDTH       = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bhit_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output bhit_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  bhit_pkg::cfg_reg_t  cfg_index,
  input  logic [bhit_pkg::MULT_WIDTH-1:0] cfg_data
);

  bhit_pkg::cmd_t  cmd;
  bhit_pkg::stat_t stat;

  bhit_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  bhit_datapath #(
    .WAYS            (WAYS),
    .MAX_BUCKET_BITS (MAX_BUCKET_BITS),
    .KEY_WIDTH       (KEY_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
